// File: rtl/arpc_pkg.sv
// arp cache package: constants, status codes and the cell link type
// used by arpc_cell and arp_cache_and_responder_core
package arpc_pkg;
   localparam int ENTRIES_DEFAULT = 32;
   localparam logic [31:0] LIFETIME_RESET = 32'd60000000;
   localparam logic [15:0] HDR_MIN_LEN = 16'd28;
   localparam logic [15:0] HW_TYPE_ETH = 16'd1;
   localparam logic [15:0] PROTO_IPV4 = 16'h0800;
   localparam logic [15:0] OPC_REQUEST = 16'd1;
   localparam logic [15:0] OPC_REPLY = 16'd2;
   localparam logic [1:0] SOP_NONE = 2'd0;
   localparam logic [1:0] SOP_REQ = 2'd1;
   localparam logic [1:0] SOP_REP = 2'd2;
   localparam logic [2:0] ST_HIT = 3'd0;
   localparam logic [2:0] ST_BCAST = 3'd1;
   localparam logic [2:0] ST_MISS = 3'd2;
   localparam logic [2:0] ST_REFUSED = 3'd3;
   localparam logic [2:0] ST_ACCEPTED = 3'd4;
   localparam logic [2:0] ST_REPLY = 3'd5;
   localparam logic [1:0] CSR_OWN_IP = 2'd0;
   localparam logic [1:0] CSR_MASK = 2'd1;
   localparam logic [1:0] CSR_OWN_MAC = 2'd2;
   localparam logic [1:0] CSR_LIFETIME = 2'd3;

   // control word driven to each cell of the chain
   typedef struct packed {
      logic        shift;
      logic        load;
      logic        set_valid;
      logic        clr_valid;
   } cell_ctl_type;
endpackage

// File: rtl/arpc_cell.sv
// one cache entry cell of the rotating chain
// depends on arpc_pkg
module arpc_cell import arpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         prev_valid,
   input  logic [31:0]  prev_ip,
   input  logic [47:0]  prev_mac,
   input  logic [31:0]  prev_time,
   input  logic [31:0]  new_ip,
   input  logic [47:0]  new_mac,
   input  logic [31:0]  new_time,
   output logic         valid,
   output logic [31:0]  ip,
   output logic [47:0]  mac,
   output logic [31:0]  etime
);
   logic valid_ff;
   logic [31:0] ip_ff, time_ff;
   logic [47:0] mac_ff;

   // valid bit follows the rotation, head cell can be set or cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.set_valid) begin
         valid_ff <= 1'b1;
      end else if (ctl.clr_valid) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         valid_ff <= prev_valid;
      end
   end

   // payload: rotate or load a learned entry
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         ip_ff <= new_ip;
         mac_ff <= new_mac;
         time_ff <= new_time;
      end else if (ctl.shift) begin
         ip_ff <= prev_ip;
         mac_ff <= prev_mac;
         time_ff <= prev_time;
      end
   end

   assign valid = valid_ff;
   assign ip = ip_ff;
   assign mac = mac_ff;
   assign etime = time_ff;
endmodule

// File: rtl/arp_cache_and_responder_core.sv
// arp cache and responder top level
// depends on arpc_pkg and arpc_cell
// Usage: an item is transferred when start is high and busy is low; mode 0
// is an address lookup, mode 1 a received ARP header. Each item gives one
// result on the rsp_ ports, marked by rsp_valid for one cycle; the receiver
// cannot stall it. Configuration registers are written on the csr_ channel
// (index 0 own_ip, 1 subnet_mask, 2 own_mac, 3 entry_lifetime) while idle.
// The cache is a ring of ENTRIES cells that rotates by one cell per cycle
// while scanning or seeking. Broadcast lookups, refused headers and headers
// that learn nothing answer straight after decode. A lookup rotates the ring
// once fully comparing the head cell and then answers. A stale hit or a
// learning header then rotates to the chosen slot, clears or writes it and
// rotates back home before it answers; when the slot is the first one it
// answers without the return pass. busy stays high through the result cycle
// and falls in the cycle after it, so the next transfer can end that cycle.
// The ring rotation sets the rate. Reset clears all valid bits at once and
// restores the register reset values.
module arp_cache_and_responder_core import arpc_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic         req_mode,
   input  logic [31:0]  req_timestamp,
   input  logic [31:0]  req_lookup_ip,
   input  logic [15:0]  req_frame_length,
   input  logic [15:0]  req_hw_type,
   input  logic [15:0]  req_proto_type,
   input  logic [7:0]   req_hw_addr_len,
   input  logic [7:0]   req_proto_addr_len,
   input  logic [15:0]  req_opcode,
   input  logic [47:0]  req_src_mac,
   input  logic [31:0]  req_src_ip,
   input  logic [31:0]  req_dst_ip,
   output logic         rsp_valid,
   output logic [2:0]   rsp_status,
   output logic [47:0]  rsp_resolved_mac,
   output logic [1:0]   rsp_send_opcode,
   output logic [47:0]  rsp_send_peer_mac,
   output logic [31:0]  rsp_send_peer_ip,
   output logic [47:0]  rsp_frame_dest_mac,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_SEEK = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [31:0] own_ip_ff, mask_ff, life_ff;
   logic [47:0] own_mac_ff;

   logic mode_ff;
   logic [31:0] now_ff, lip_ff, sip_ff, tip_ff;
   logic [15:0] len_ff, hw_ff, pr_ff, op_ff;
   logic [7:0] hl_ff, pl_ff;
   logic [47:0] smac_ff;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic found_ff, found_in, free_ff, free_in;
   logic [CW-1:0] slot_ff, slot_in, old_ff, old_in;
   logic [31:0] best_ff, best_in;
   logic [47:0] hmac_ff, hmac_in;
   logic fresh_ff, fresh_in;
   logic learn_ff, learn_in;
   logic [CW-1:0] target_ff, target_in;
   logic back_ff;

   logic [2:0] st_ff, st_in;
   logic [47:0] rmac_ff, rmac_in, stmac_ff, stmac_in, fdst_ff, fdst_in;
   logic [1:0] sop_ff, sop_in;
   logic [31:0] stip_ff, stip_in;

   cell_ctl_type ctl [ENTRIES];
   logic v [ENTRIES];
   logic [31:0] cip [ENTRIES];
   logic [47:0] cmac [ENTRIES];
   logic [31:0] ctm [ENTRIES];

   // the ring: cell i takes from cell i+1, head is cell 0
   for (genvar g = 0; g < ENTRIES; g++) begin : g_ring
      localparam int NX = (g + 1) % ENTRIES;
      arpc_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl[g]),
         .prev_valid(v[NX]), .prev_ip(cip[NX]), .prev_mac(cmac[NX]),
         .prev_time(ctm[NX]), .new_ip(sip_ff), .new_mac(smac_ff),
         .new_time(now_ff), .valid(v[g]), .ip(cip[g]), .mac(cmac[g]),
         .etime(ctm[g])
      );
   end

   wire do_shift = (state_ff == S_SCAN) || (state_ff == S_SEEK && cnt_ff != target_ff);
   wire head_match = v[0] && (cip[0] == (mode_ff ? sip_ff : lip_ff));
   wire [31:0] head_age = now_ff - ctm[0];
   wire at_slot = (state_ff == S_SEEK) && (cnt_ff == target_ff) && !back_ff;
   wire lk_clear = at_slot && !mode_ff;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         ctl[i].shift = do_shift;
         ctl[i].load = (i == 0) && at_slot && mode_ff;
         ctl[i].set_valid = (i == 0) && at_slot && mode_ff;
         ctl[i].clr_valid = (i == 0) && lk_clear;
      end
   end

   wire [31:0] host = ~mask_ff;
   wire bcast = (lip_ff == 32'hFFFFFFFF) ||
                (mask_ff != 32'd0 && host != 32'd0 && (lip_ff | host) == lip_ff);
   wire refused = len_ff < HDR_MIN_LEN || hw_ff != HW_TYPE_ETH ||
                  pr_ff != PROTO_IPV4 || hl_ff != 8'd6 || pl_ff != 8'd4;
   wire for_us = own_ip_ff != 32'd0 && tip_ff == own_ip_ff;
   wire can_learn = (for_us || op_ff == OPC_REPLY) && sip_ff != 32'd0 &&
                    sip_ff != 32'hFFFFFFFF && smac_ff != 48'd0;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      found_in = found_ff; free_in = free_ff;
      slot_in = slot_ff; old_in = old_ff; best_in = best_ff;
      hmac_in = hmac_ff; fresh_in = fresh_ff;
      learn_in = learn_ff; target_in = target_ff;
      st_in = st_ff; rmac_in = rmac_ff; sop_in = sop_ff;
      stmac_in = stmac_ff; stip_in = stip_ff; fdst_in = fdst_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            rmac_in = '0; sop_in = SOP_NONE; stmac_in = '0; stip_in = '0; fdst_in = '0;
            cnt_in = '0; found_in = 1'b0; free_in = 1'b0; best_in = '0; old_in = '0;
            learn_in = 1'b0;
            if (!mode_ff) begin
               if (bcast) begin
                  st_in = ST_BCAST; rmac_in = '1; state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (refused) begin
               st_in = ST_REFUSED; state_in = S_DONE;
            end else begin
               learn_in = can_learn;
               if (op_ff == OPC_REQUEST && for_us) begin
                  st_in = ST_REPLY; sop_in = SOP_REP; stmac_in = smac_ff;
                  stip_in = sip_ff; fdst_in = smac_ff;
               end else begin
                  st_in = ST_ACCEPTED;
               end
               state_in = can_learn ? S_SCAN : S_DONE;
            end
         end
         S_SCAN: begin
            // head cell holds original entry cnt_ff
            if (head_match && !found_in) begin
               found_in = 1'b1; slot_in = cnt_ff; hmac_in = cmac[0];
               fresh_in = head_age < life_ff;
            end
            if (!v[0] && !free_ff) begin
               free_in = 1'b1; old_in = cnt_ff;
            end else if (!free_ff && (cnt_ff == '0 || head_age > best_ff)) begin
               best_in = head_age; old_in = cnt_ff;
            end
            if (cnt_ff == LAST) begin
               cnt_in = '0;
               if (!mode_ff) begin
                  if (found_in && fresh_in) begin
                     st_in = ST_HIT; rmac_in = hmac_in; state_in = S_DONE;
                  end else begin
                     st_in = ST_MISS; sop_in = SOP_REQ; stip_in = lip_ff;
                     fdst_in = '1;
                     target_in = slot_in;
                     state_in = found_in ? S_SEEK : S_DONE;
                  end
               end else begin
                  target_in = found_in ? slot_in : old_in;
                  state_in = S_SEEK;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SEEK: begin
            // first pass stops at the slot, second pass stops back home
            if (cnt_ff != target_ff) begin
               cnt_in = cnt_ff + 1'b1;
            end else if (back_ff) begin
               state_in = S_DONE;
            end else begin
               cnt_in = '0; target_in = CW'(ENTRIES) - target_ff;
               state_in = (target_ff == '0) ? S_DONE : S_WRITE;
            end
         end
         S_WRITE: begin
            // set up the second seek, which rotates the rest of the way back home
            cnt_in = '0;
            state_in = S_SEEK;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // S_WRITE leads into a second seek whose target is the remaining distance;
   // the back flag marks that pass
   always_ff @(posedge clock) begin
      if (reset) begin
         back_ff <= 1'b0;
      end else if (state_ff == S_DECODE) begin
         back_ff <= 1'b0;
      end else if (state_ff == S_WRITE) begin
         back_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         own_ip_ff <= '0; mask_ff <= '0; own_mac_ff <= '0; life_ff <= LIFETIME_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_OWN_IP: own_ip_ff <= csr_data[31:0];
               CSR_MASK: mask_ff <= csr_data[31:0];
               CSR_OWN_MAC: own_mac_ff <= csr_data[47:0];
               CSR_LIFETIME: life_ff <= csr_data[31:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         mode_ff <= req_mode; now_ff <= req_timestamp; lip_ff <= req_lookup_ip;
         len_ff <= req_frame_length; hw_ff <= req_hw_type; pr_ff <= req_proto_type;
         hl_ff <= req_hw_addr_len; pl_ff <= req_proto_addr_len; op_ff <= req_opcode;
         smac_ff <= req_src_mac; sip_ff <= req_src_ip; tip_ff <= req_dst_ip;
      end
      cnt_ff <= cnt_in; found_ff <= found_in; free_ff <= free_in;
      slot_ff <= slot_in; old_ff <= old_in; best_ff <= best_in;
      hmac_ff <= hmac_in; fresh_ff <= fresh_in; learn_ff <= learn_in;
      target_ff <= target_in;
      st_ff <= st_in; rmac_ff <= rmac_in; sop_ff <= sop_in;
      stmac_ff <= stmac_in; stip_ff <= stip_in; fdst_ff <= fdst_in;
   end

   assign busy = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = state_ff == S_DONE;
   assign rsp_status = st_ff;
   assign rsp_resolved_mac = rmac_ff;
   assign rsp_send_opcode = sop_ff;
   assign rsp_send_peer_mac = stmac_ff;
   assign rsp_send_peer_ip = stip_ff;
   assign rsp_frame_dest_mac = fdst_ff;

   // own_mac is held for outgoing frames; not part of the result fields
   logic own_mac_unused;
   assign own_mac_unused = ^own_mac_ff;

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_no_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("block not idle after result");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> cnt_ff <= LAST) else $error("scan counter out of range");
   a_load: assert property (@(posedge clock) disable iff (reset)
      ctl[0].load |-> learn_ff) else $error("cache written without learning");
endmodule

// File: tb/sv/arp_cache_and_responder_core_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the arp cache and responder core
// depends on arpc_pkg and arp_cache_and_responder_core; stands alone otherwise
module arp_cache_and_responder_core_test;
   import arpc_pkg::*;

   localparam int NUM_ENTRIES = ENTRIES_DEFAULT;
   localparam int DRAIN_CYCLES = 2 * NUM_ENTRIES + 10;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int NUM_DIRECTED = 17;
   localparam int CONFIG_ROW = 6;
   localparam int POOL_SIZE = 48;

   typedef struct {
      logic        mode;
      logic [31:0] timestamp;
      logic [31:0] lookup_ip;
      logic [15:0] frame_length;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [7:0]  hw_addr_len;
      logic [7:0]  proto_addr_len;
      logic [15:0] opcode;
      logic [47:0] src_mac;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
   } arp_item_type;

   typedef struct {
      logic [2:0]  status;
      logic [47:0] resolved_mac;
      logic [1:0]  send_opcode;
      logic [47:0] send_peer_mac;
      logic [31:0] send_peer_ip;
      logic [47:0] frame_dest_mac;
   } arp_answer_type;

   typedef struct {
      arp_item_type   item;
      bit             typed;
      arp_answer_type answer;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = 1'b0;
   logic [31:0] req_timestamp = '0;
   logic [31:0] req_lookup_ip = '0;
   logic [15:0] req_frame_length = '0;
   logic [15:0] req_hw_type = '0;
   logic [15:0] req_proto_type = '0;
   logic [7:0]  req_hw_addr_len = '0;
   logic [7:0]  req_proto_addr_len = '0;
   logic [15:0] req_opcode = '0;
   logic [47:0] req_src_mac = '0;
   logic [31:0] req_src_ip = '0;
   logic [31:0] req_dst_ip = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [47:0] rsp_resolved_mac;
   logic [1:0]  rsp_send_opcode;
   logic [47:0] rsp_send_peer_mac;
   logic [31:0] rsp_send_peer_ip;
   logic [47:0] rsp_frame_dest_mac;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   arp_cache_and_responder_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_timestamp(req_timestamp), .req_lookup_ip(req_lookup_ip),
      .req_frame_length(req_frame_length), .req_hw_type(req_hw_type),
      .req_proto_type(req_proto_type), .req_hw_addr_len(req_hw_addr_len),
      .req_proto_addr_len(req_proto_addr_len), .req_opcode(req_opcode),
      .req_src_mac(req_src_mac), .req_src_ip(req_src_ip),
      .req_dst_ip(req_dst_ip), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_resolved_mac(rsp_resolved_mac), .rsp_send_opcode(rsp_send_opcode),
      .rsp_send_peer_mac(rsp_send_peer_mac), .rsp_send_peer_ip(rsp_send_peer_ip),
      .rsp_frame_dest_mac(rsp_frame_dest_mac), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // shadow copy of the cache and registers
   logic [31:0] shadow_own_ip;
   logic [31:0] shadow_mask;
   logic [47:0] shadow_own_mac;
   logic [31:0] shadow_lifetime;
   bit          cache_valid [NUM_ENTRIES];
   logic [31:0] cache_ip [NUM_ENTRIES];
   logic [47:0] cache_mac [NUM_ENTRIES];
   logic [31:0] cache_time [NUM_ENTRIES];

   arp_answer_type pending_answers[$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          answers_seen = 0;
   int          idle_cycles = 0;
   logic [31:0] ip_pool [POOL_SIZE];
   logic [31:0] now_ticks = '0;
   int          status_hist [8];

   function automatic int find_entry(logic [31:0] ip);
      for (int i = 0; i < NUM_ENTRIES; i++)
         if (cache_valid[i] && cache_ip[i] == ip) return i;
      return -1;
   endfunction

   // learn a valid sender: refresh, else first free slot, else the oldest
   function automatic void learn_sender(logic [31:0] ip, logic [47:0] mac, logic [31:0] now);
      int          slot;
      logic [31:0] oldest;
      logic [31:0] age;
      if (ip == '0 || ip == '1 || mac == '0) return;
      slot = find_entry(ip);
      if (slot < 0)
         for (int i = 0; i < NUM_ENTRIES; i++)
            if (!cache_valid[i]) begin
               slot = i;
               break;
            end
      if (slot < 0) begin
         slot = 0;
         oldest = now - cache_time[0];
         for (int i = 1; i < NUM_ENTRIES; i++) begin
            age = now - cache_time[i];
            if (age > oldest) begin
               oldest = age;
               slot = i;
            end
         end
      end
      cache_ip[slot] = ip;
      cache_mac[slot] = mac;
      cache_time[slot] = now;
      cache_valid[slot] = 1'b1;
   endfunction

   // predict the answer for one item and update the shadow cache
   function automatic arp_answer_type resolve_item(arp_item_type it);
      arp_answer_type a;
      logic [31:0] host;
      int          s;
      bit          for_us;
      a = '{ST_ACCEPTED, '0, SOP_NONE, '0, '0, '0};
      if (it.mode == 1'b0) begin
         host = ~shadow_mask;
         if (it.lookup_ip == '1 ||
             (shadow_mask != '0 && host != '0 && (it.lookup_ip | host) == it.lookup_ip)) begin
            a.status = ST_BCAST;
            a.resolved_mac = '1;
         end else begin
            s = find_entry(it.lookup_ip);
            if (s >= 0 && (it.timestamp - cache_time[s]) < shadow_lifetime) begin
               a.status = ST_HIT;
               a.resolved_mac = cache_mac[s];
            end else begin
               if (s >= 0) cache_valid[s] = 1'b0;
               a.status = ST_MISS;
               a.send_opcode = SOP_REQ;
               a.send_peer_ip = it.lookup_ip;
               a.frame_dest_mac = '1;
            end
         end
      end else if (it.frame_length < HDR_MIN_LEN || it.hw_type != HW_TYPE_ETH ||
                   it.proto_type != PROTO_IPV4 || it.hw_addr_len != 8'd6 ||
                   it.proto_addr_len != 8'd4) begin
         a.status = ST_REFUSED;
      end else begin
         for_us = shadow_own_ip != '0 && it.dst_ip == shadow_own_ip;
         if (for_us || it.opcode == OPC_REPLY)
            learn_sender(it.src_ip, it.src_mac, it.timestamp);
         if (it.opcode == OPC_REQUEST && for_us) begin
            a.status = ST_REPLY;
            a.send_opcode = SOP_REP;
            a.send_peer_mac = it.src_mac;
            a.send_peer_ip = it.src_ip;
            a.frame_dest_mac = it.src_mac;
         end
      end
      return a;
   endfunction

   function automatic arp_item_type mk_lookup(logic [31:0] ts, logic [31:0] ip);
      arp_item_type it;
      it = '{1'b0, ts, ip, 16'd28, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4,
             OPC_REQUEST, 48'h0, 32'h0, 32'h0};
      return it;
   endfunction

   function automatic arp_item_type mk_header(logic [31:0] ts, logic [15:0] len,
         logic [15:0] hw, logic [15:0] pr, logic [7:0] hl, logic [7:0] pl,
         logic [15:0] op, logic [47:0] smac, logic [31:0] sip, logic [31:0] tip);
      arp_item_type it;
      it = '{1'b1, ts, $urandom, len, hw, pr, hl, pl, op, smac, sip, tip};
      return it;
   endfunction

   function automatic arp_answer_type refused_answer();
      arp_answer_type a;
      a = '{ST_REFUSED, '0, SOP_NONE, '0, '0, '0};
      return a;
   endfunction

   // transfer one item after an optional gap; prediction at acceptance
   task automatic send_item(arp_item_type it, int gap, bit typed,
                            arp_answer_type typed_answer);
      arp_answer_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= it.mode;
      req_timestamp <= it.timestamp;
      req_lookup_ip <= it.lookup_ip;
      req_frame_length <= it.frame_length;
      req_hw_type <= it.hw_type;
      req_proto_type <= it.proto_type;
      req_hw_addr_len <= it.hw_addr_len;
      req_proto_addr_len <= it.proto_addr_len;
      req_opcode <= it.opcode;
      req_src_mac <= it.src_mac;
      req_src_ip <= it.src_ip;
      req_dst_ip <= it.dst_ip;
      do @(posedge clock); while (busy);
      predicted = resolve_item(it);
      pending_answers.push_back(typed ? typed_answer : predicted);
      items_sent++;
   endtask

   // register write once every answer is back
   task automatic write_reg(logic [1:0] idx, logic [63:0] value);
      start <= 1'b0;
      wait (pending_answers.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_OWN_IP:  shadow_own_ip = value[31:0];
         CSR_MASK:    shadow_mask = value[31:0];
         CSR_OWN_MAC: shadow_own_mac = value[47:0];
         default:     shadow_lifetime = value[31:0];
      endcase
   endtask

   task automatic configure(logic [31:0] ip, logic [31:0] mask, logic [47:0] mac,
                            logic [31:0] life);
      write_reg(CSR_OWN_IP, {$urandom, ip});
      write_reg(CSR_MASK, {$urandom, mask});
      write_reg(CSR_OWN_MAC, {16'($urandom), mac});
      write_reg(CSR_LIFETIME, {$urandom, life});
   endtask

   function automatic int pick_gap(bit quiet);
      if (quiet) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_ip();
      return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // random item: mostly well-formed lookups and headers, some noise
   function automatic arp_item_type random_item();
      arp_item_type it;
      int        kind;
      logic [15:0] op;
      logic [31:0] sip;
      logic [47:0] smac;
      case ($urandom_range(0, 19))
         0:       now_ticks = $urandom;
         1:       now_ticks = now_ticks + $urandom_range(1000, 100000);
         default: now_ticks = now_ticks + $urandom_range(0, 60);
      endcase
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
         it = mk_lookup(now_ticks, (kind == 0) ? $urandom : pick_ip());
         it.frame_length = 16'($urandom);
         it.hw_type = 16'($urandom);
         it.opcode = 16'($urandom);
         it.src_mac = rand48();
         it.src_ip = $urandom;
         it.dst_ip = $urandom;
         return it;
      end
      op = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
           (($urandom_range(0, 1) == 0) ? OPC_REQUEST : OPC_REPLY);
      case ($urandom_range(0, 19))
         0:       sip = '0;
         1:       sip = '1;
         2:       sip = $urandom;
         default: sip = pick_ip();
      endcase
      smac = ($urandom_range(0, 19) == 0) ? 48'h0 : rand48();
      it = mk_header(now_ticks, 16'($urandom_range(28, 65535)), HW_TYPE_ETH,
                     PROTO_IPV4, 8'd6, 8'd4, op, smac, sip,
                     ($urandom_range(0, 1) == 0) ? shadow_own_ip : pick_ip());
      // broken header: one or all fields spoiled
      if (kind >= 17) begin
         case ($urandom_range(0, 5))
            0: it.frame_length = 16'($urandom_range(0, 27));
            1: it.hw_type = 16'($urandom);
            2: it.proto_type = 16'($urandom);
            3: it.hw_addr_len = 8'($urandom);
            4: it.proto_addr_len = 8'($urandom);
            default: begin
               it.frame_length = 16'($urandom);
               it.hw_type = 16'($urandom);
               it.proto_type = 16'($urandom);
               it.hw_addr_len = 8'($urandom);
               it.proto_addr_len = 8'($urandom);
            end
         endcase
      end
      return it;
   endfunction

   // result check against the oldest expectation
   always @(posedge clock) begin
      arp_answer_type want;
      if (!reset && rsp_valid) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result, status %0d", rsp_status);
         end else begin
            want = pending_answers.pop_front();
            status_hist[want.status]++;
            if (rsp_status !== want.status || rsp_resolved_mac !== want.resolved_mac ||
                rsp_send_opcode !== want.send_opcode ||
                rsp_send_peer_mac !== want.send_peer_mac ||
                rsp_send_peer_ip !== want.send_peer_ip ||
                rsp_frame_dest_mac !== want.frame_dest_mac) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp st %0d mac %h op %0d tmac %h tip %h dst %h",
                            " / got st %0d mac %h op %0d tmac %h tip %h dst %h"},
                     want.status, want.resolved_mac, want.send_opcode, want.send_peer_mac,
                     want.send_peer_ip, want.frame_dest_mac, rsp_status, rsp_resolved_mac,
                     rsp_send_opcode, rsp_send_peer_mac, rsp_send_peer_ip,
                     rsp_frame_dest_mac);
            end
         end
      end
   end

   // watchdog on cycles with no transfer of any kind
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_answers.size());
         $display("arp_cache_and_responder_core_test failed");
         $finish;
      end
   end

   directed_row_type directed [NUM_DIRECTED];

   initial begin
      arp_answer_type none;
      arp_answer_type a;
      bit          quiet;
      none = '{ST_ACCEPTED, '0, SOP_NONE, '0, '0, '0};
      shadow_own_ip = '0;
      shadow_mask = '0;
      shadow_own_mac = '0;
      shadow_lifetime = LIFETIME_RESET;
      for (int i = 0; i < NUM_ENTRIES; i++) cache_valid[i] = 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) ip_pool[i] = $urandom | 32'h1;

      // rows up to the config point run with reset register values
      a = '{ST_BCAST, '1, SOP_NONE, '0, '0, '0};
      directed[0] = '{mk_lookup(32'd0, 32'hffff_ffff), 1'b1, a};
      a = '{ST_MISS, '0, SOP_REQ, '0, 32'h0, '1};
      directed[1] = '{mk_lookup(32'hffff_ffff, 32'h0), 1'b1, a};
      directed[2] = '{mk_header(0, 16'd27, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4,
                      OPC_REPLY, '1, 32'h0a000009, 32'h0), 1'b1, refused_answer()};
      directed[3] = '{mk_header(0, 16'hffff, 16'hffff, PROTO_IPV4, 8'd6, 8'd4,
                      OPC_REPLY, '1, 32'h0a000009, 32'h0), 1'b1, refused_answer()};
      directed[4] = '{mk_header(0, 16'd28, HW_TYPE_ETH, 16'h0, 8'd6, 8'd4,
                      OPC_REPLY, '1, 32'h0a000009, 32'h0), 1'b1, refused_answer()};
      directed[5] = '{mk_header(0, 16'd28, HW_TYPE_ETH, PROTO_IPV4, 8'hff, 8'h0,
                      OPC_REPLY, '1, 32'h0a000009, 32'h0), 1'b1, refused_answer()};
      // learn, hit, subnet broadcast, reply, expiry, skipped senders, wrap
      directed[6] = '{mk_header(32'd10, 16'd28, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4,
                      OPC_REPLY, 48'h0200_0000_0005, 32'h0a000005, 32'h0a000063), 1'b0, none};
      directed[7] = '{mk_lookup(32'd20, 32'h0a000005), 1'b0, none};
      directed[8] = '{mk_lookup(32'd21, 32'h0a0000ff), 1'b0, none};
      directed[9] = '{mk_header(32'd30, 16'd28, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4,
                      OPC_REQUEST, 48'h0200_0000_0007, 32'h0a000007, 32'h0a000001), 1'b0, none};
      directed[10] = '{mk_lookup(32'd200, 32'h0a000005), 1'b0, none};
      directed[11] = '{mk_lookup(32'd201, 32'h0a000005), 1'b0, none};
      directed[12] = '{mk_header(32'd202, 16'd28, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4,
                      16'd3, 48'h0200_0000_0008, 32'h0, 32'h0a000001), 1'b0, none};
      directed[13] = '{mk_header(32'd203, 16'd28, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4,
                      OPC_REPLY, 48'h0200_0000_0009, 32'hffff_ffff, 32'h0), 1'b0, none};
      directed[14] = '{mk_header(32'd204, 16'd28, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4,
                      OPC_REPLY, 48'h0, 32'h0a00000a, 32'h0), 1'b0, none};
      directed[15] = '{mk_header(32'd205, 16'hffff, HW_TYPE_ETH, PROTO_IPV4, 8'd6, 8'd4,
                      16'h0, '1, 32'h0a00000b, 32'h0a000002), 1'b0, none};
      directed[16] = '{mk_lookup(32'd25, 32'h0a000007), 1'b0, none};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NUM_DIRECTED; r++) begin
         if (r == CONFIG_ROW)
            configure(32'h0a000001, 32'hffff_ff00, 48'h0200_0000_0001, 32'd100);
         send_item(directed[r].item, pick_gap(1'b0), directed[r].typed, directed[r].answer);
      end

      // random phases over several register settings
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: configure(pick_ip(), 32'h0, rand48(), 32'd1);
            1: configure(pick_ip(), 32'hffff_ffff, '1, 32'hffff_ffff);
            2: configure(32'h0, 32'h8000_0000, 48'h0, 32'd300);
            3: configure(pick_ip(), 32'hffff_ff00, rand48(), 32'd2000);
            default: configure(pick_ip(), $urandom, rand48(), $urandom_range(50, 5000));
         endcase
         for (int n = 0; n < 200; n++) begin
            if (n % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
            send_item(random_item(), pick_gap(quiet), 1'b0, none);
         end
      end
      start <= 1'b0;

      wait (pending_answers.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d items, %0d results: hit %0d bcast %0d miss %0d refused %0d accepted %0d reply %0d",
         items_sent, answers_seen, status_hist[ST_HIT], status_hist[ST_BCAST],
         status_hist[ST_MISS], status_hist[ST_REFUSED], status_hist[ST_ACCEPTED],
         status_hist[ST_REPLY]);
      $display("six register settings, %0d mismatches", mismatches);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("arp_cache_and_responder_core_test passed");
      else
         $display("arp_cache_and_responder_core_test failed");
      $finish;
   end
endmodule

// File: filelist.f
rtl/arpc_pkg.sv
rtl/arpc_cell.sv
rtl/arp_cache_and_responder_core.sv
tb/sv/arp_cache_and_responder_core_test.sv
